>>> rtl/ptb_pkg.sv
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared constants for the percentile threshold binarizer: field widths,
// register map, stream codes and parameter defaults.
// ----------------------------------------------------------------------------
package ptb_pkg;

   localparam int DEF_MAX_PIXELS  = 1048576;
   localparam int DEF_GRAY_LEVELS = 256;

   localparam int PIXEL_W   = 8;
   localparam int PROP_W    = 17;
   localparam int Q16_SHIFT = 16;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int REQ_USR_W = 2;
   localparam int RSP_USR_W = 1;
   localparam int RSP_DAT_W = 2 * PIXEL_W;

   localparam logic [PROP_W-1:0] Q16_ONE    = PROP_W'(65536);
   localparam logic [PROP_W-1:0] PROP_RESET = PROP_W'(32768);

   // register index, taken from the word address bit
   localparam logic REG_PROPORTION = 1'b0;
   localparam logic REG_USE_MASK   = 1'b1;

   localparam logic FUNC_COUNT    = 1'b0;
   localparam logic FUNC_BINARIZE = 1'b1;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_PIXEL  = 1'b1;

   localparam logic [PIXEL_W-1:0] PIX_LOW  = 8'd0;
   localparam logic [PIXEL_W-1:0] PIX_HIGH = 8'd255;

endpackage

>>> rtl/percentile_threshold_binarizer.sv
// ----------------------------------------------------------------------------
// percentile_threshold_binarizer
// Two-pass p-tile thresholding: histogram count, bin walk, then binarize.
// ----------------------------------------------------------------------------
// Counting beats (tuser[0] = 0) and binarizing beats (tuser[0] = 1) are taken
// at one per cycle while no bin walk is pending and the output register is
// free; the histogram sits in a single RAM with registered read data, updated
// by read-modify-write with forwarding of the previous write, so repeated gray
// levels need no stall. A counting beat with tlast set closes the pass: the
// block stops taking beats while it settles the count, forms the target, waits
// on the RAM read, reads one bin at a time until the running sum reaches the
// target (or the top gray level), and loads the report; it then returns one
// report beat carrying the new threshold. Bins are cleared at once by per-bin
// valid flags when a new counting pass starts and at reset, so there is no
// clearing sweep. Results go through one output register; while a result waits
// on rsp_tready no new beat is taken, and the next beat is taken in the cycle
// the waiting result leaves.
// ----------------------------------------------------------------------------
module percentile_threshold_binarizer #(
   parameter int MAX_PIXELS  = ptb_pkg::DEF_MAX_PIXELS,
   parameter int GRAY_LEVELS = ptb_pkg::DEF_GRAY_LEVELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ptb_pkg::PIXEL_W-1:0]     req_tdata,   // pixel
   input  logic                            req_tlast,   // last
   input  logic [ptb_pkg::REQ_USR_W-1:0]   req_tuser,   // func, in_mask
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ptb_pkg::RSP_DAT_W-1:0]   rsp_tdata,   // value, threshold
   output logic [ptb_pkg::RSP_USR_W-1:0]   rsp_tuser,   // kind
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ptb_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [ptb_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [ptb_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                            csr_pready
);

   import ptb_pkg::*;

   localparam int LVL_W  = $clog2(GRAY_LEVELS);
   localparam int BINS   = 1 << LVL_W;
   localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int RUN_W  = CNT_W + LVL_W;
   localparam int PROD_W = PROP_W + CNT_W;
   localparam int TGT_W  = PROD_W - Q16_SHIFT;

   localparam logic [CNT_W-1:0]   CNT_MAX  = CNT_W'(MAX_PIXELS);
   localparam logic [LVL_W-1:0]   LVL_TOP  = LVL_W'(GRAY_LEVELS - 1);
   localparam logic [PIXEL_W:0]   LVL_LIM  = (PIXEL_W + 1)'(GRAY_LEVELS);

   localparam logic [2:0] ST_RUN    = 3'd0;
   localparam logic [2:0] ST_WAIT   = 3'd1;
   localparam logic [2:0] ST_TGT    = 3'd2;
   localparam logic [2:0] ST_WALK   = 3'd3;
   localparam logic [2:0] ST_REPORT = 3'd4;

   // configuration
   logic [PROP_W-1:0]  proportion_ff, proportion_in;
   logic               use_mask_ff, use_mask_in;
   logic               csr_wr;

   // control
   logic [2:0]         state_ff, state_in;
   logic               binarizing_ff, binarizing_in;
   logic [CNT_W-1:0]   counted_ff, counted_in;
   logic [LVL_W-1:0]   threshold_ff, threshold_in;
   logic [BINS-1:0]    valid_ff, valid_in;

   // counting pipeline
   logic               s1_inc_ff;
   logic [LVL_W-1:0]   s1_bin_ff;
   logic               rdv_ff, rdv_in;
   logic               fw_valid_ff;
   logic [LVL_W-1:0]   fw_bin_ff;
   logic [CNT_W-1:0]   fw_data_ff;

   // bin walk
   logic [TGT_W-1:0]   target_ff;
   logic [LVL_W-1:0]   walk_addr_ff;
   logic               w1_valid_ff;
   logic [LVL_W-1:0]   w1_lvl_ff;
   logic [RUN_W-1:0]   walk_run_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff;
   logic [PIXEL_W-1:0] rsp_value_ff;
   logic [PIXEL_W-1:0] rsp_thr_ff;

   // datapath
   logic               req_acc, in_func, in_mask, out_free;
   logic               cnt_acc, new_pass, counts;
   logic [LVL_W-1:0]   bin_sel, ram_raddr;
   logic [CNT_W-1:0]   ram_rdata, old_cnt, new_cnt, w1_cnt;
   logic [PROP_W-1:0]  prop_eff;
   logic [PROD_W-1:0]  product;
   logic [RUN_W-1:0]   walk_sum;
   logic               walk_hit, load_bin, load_rep;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      proportion_in = proportion_ff;
      use_mask_in   = use_mask_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_PROPORTION: proportion_in = csr_pwdata[PROP_W-1:0];
            REG_USE_MASK:   use_mask_in   = csr_pwdata[0];
            default:        proportion_in = proportion_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_PROPORTION: csr_prdata = CSR_DW'(proportion_ff);
         REG_USE_MASK:   csr_prdata = CSR_DW'(use_mask_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- input
   assign in_func  = req_tuser[0];
   assign in_mask  = req_tuser[1];
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_RUN) && out_free;
   assign req_acc    = req_tvalid && req_tready;
   assign cnt_acc    = req_acc && (in_func == FUNC_COUNT);
   assign load_bin   = req_acc && (in_func == FUNC_BINARIZE);
   assign new_pass   = cnt_acc && binarizing_ff;
   assign counts     = !use_mask_ff || in_mask;

   // levels at or above GRAY_LEVELS land in the bin of the top gray level
   assign bin_sel = ({1'b0, req_tdata} >= LVL_LIM) ? LVL_TOP : req_tdata[LVL_W-1:0];

   assign ram_raddr = (state_ff == ST_WALK) ? walk_addr_ff : bin_sel;

   ptb_ram #(
      .WIDTH (CNT_W),
      .DEPTH (BINS)
   ) u_hist (
      .clock (clock),
      .we    (s1_inc_ff),
      .waddr (s1_bin_ff),
      .wdata (new_cnt),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // a bin cleared by a new pass reads as zero even though the ram still holds data
   assign rdv_in = new_pass ? 1'b0 : valid_ff[ram_raddr];

   // ---------------------------------------------------------------- count update
   always_comb begin
      if (fw_valid_ff && (fw_bin_ff == s1_bin_ff)) begin
         old_cnt = fw_data_ff;
      end else if (rdv_ff) begin
         old_cnt = ram_rdata;
      end else begin
         old_cnt = '0;
      end
      new_cnt = (old_cnt >= CNT_MAX) ? CNT_MAX : old_cnt + CNT_W'(1);
   end

   always_comb begin
      valid_in   = valid_ff;
      counted_in = counted_ff;
      if (s1_inc_ff) begin
         valid_in[s1_bin_ff] = 1'b1;
         counted_in = (counted_ff >= CNT_MAX) ? CNT_MAX : counted_ff + CNT_W'(1);
      end
      if (new_pass) begin
         valid_in   = '0;
         counted_in = '0;
      end
   end

   // ---------------------------------------------------------------- target and walk
   assign prop_eff = (proportion_ff > Q16_ONE) ? Q16_ONE : proportion_ff;
   assign product  = PROD_W'(prop_eff) * PROD_W'(counted_ff);

   assign w1_cnt   = rdv_ff ? ram_rdata : '0;
   assign walk_sum = walk_run_ff + RUN_W'(w1_cnt);
   assign walk_hit = (state_ff == ST_WALK) && w1_valid_ff &&
                     ((walk_sum >= RUN_W'(target_ff)) || (w1_lvl_ff == LVL_TOP));

   assign load_rep = (state_ff == ST_REPORT) && out_free;

   always_comb begin
      state_in      = state_ff;
      binarizing_in = binarizing_ff;
      threshold_in  = threshold_ff;
      if (new_pass) begin
         binarizing_in = 1'b0;
      end
      unique case (state_ff)
         ST_RUN: begin
            if (cnt_acc && req_tlast) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_TGT;
         end
         ST_TGT: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_hit) begin
               threshold_in = w1_lvl_ff;
               state_in     = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               binarizing_in = 1'b1;
               state_in      = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_bin || load_rep) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tuser[0] = rsp_kind_ff;
   assign rsp_tdata    = {rsp_thr_ff, rsp_value_ff};

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         proportion_ff <= PROP_RESET;
         use_mask_ff   <= 1'b0;
         state_ff      <= ST_RUN;
         binarizing_ff <= 1'b0;
         counted_ff    <= '0;
         threshold_ff  <= '0;
         valid_ff      <= '0;
         s1_inc_ff     <= 1'b0;
         fw_valid_ff   <= 1'b0;
         w1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         proportion_ff <= proportion_in;
         use_mask_ff   <= use_mask_in;
         state_ff      <= state_in;
         binarizing_ff <= binarizing_in;
         counted_ff    <= counted_in;
         threshold_ff  <= threshold_in;
         valid_ff      <= valid_in;
         s1_inc_ff     <= cnt_acc && counts;
         fw_valid_ff   <= s1_inc_ff;
         w1_valid_ff   <= (state_ff == ST_WALK);
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_bin_ff  <= bin_sel;
      rdv_ff     <= rdv_in;
      fw_bin_ff  <= s1_bin_ff;
      fw_data_ff <= new_cnt;
      w1_lvl_ff  <= walk_addr_ff;
      if (state_ff == ST_TGT) begin
         target_ff    <= product[PROD_W-1:Q16_SHIFT];
         walk_addr_ff <= '0;
         walk_run_ff  <= '0;
      end else begin
         walk_addr_ff <= walk_addr_ff + LVL_W'(1);
         if (w1_valid_ff) begin
            walk_run_ff <= walk_sum;
         end
      end
      if (load_bin) begin
         rsp_kind_ff  <= KIND_PIXEL;
         rsp_value_ff <= (req_tdata >= PIXEL_W'(threshold_ff)) ? PIX_HIGH : PIX_LOW;
         rsp_thr_ff   <= PIXEL_W'(threshold_ff);
      end else if (load_rep) begin
         rsp_kind_ff  <= KIND_REPORT;
         rsp_value_ff <= PIX_LOW;
         rsp_thr_ff   <= PIXEL_W'(threshold_ff);
      end
   end

   // ---------------------------------------------------------------- assertions
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (cnt_acc && req_tlast) |=> !req_tready)
      else $error("input taken while the bin walk is pending");

   a_pixel_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[0] == KIND_PIXEL)) |->
      ((rsp_tdata[PIXEL_W-1:0] == PIX_LOW) || (rsp_tdata[PIXEL_W-1:0] == PIX_HIGH)))
      else $error("binarized value is neither 0 nor 255");

   a_report: assert property (@(posedge clock) disable iff (reset)
      load_rep |=> (binarizing_ff && rsp_tvalid && (rsp_tuser[0] == KIND_REPORT)
                    && (rsp_tdata[PIXEL_W-1:0] == PIX_LOW)))
      else $error("threshold report not presented after the walk");

   a_thr_range: assert property (@(posedge clock) disable iff (reset)
      threshold_ff <= LVL_TOP)
      else $error("threshold beyond the top gray level");

endmodule

>>> rtl/ptb_ram.sv
// ----------------------------------------------------------------------------
// ptb_ram
// Generic single-write, single-read synchronous RAM with registered read
// data (read returns the contents before a same-cycle write).
// ----------------------------------------------------------------------------
module ptb_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
